// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WCAS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define WCAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/wcas_pkg.sv =====
// Shared types, codes and constants of the wildfire cell step block.
// No dependencies; compiled first.
package wcas_pkg;

  localparam int IDX_W = 12;

  // Largest grid the block holds
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  // Request codes
  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_UPDATE = 2'd1;
  localparam logic [1:0] REQ_SWAP   = 2'd2;

  // Cell burn states
  localparam logic [1:0] ST_UNBURNED = 2'd0;
  localparam logic [1:0] ST_BURNING  = 2'd1;
  localparam logic [1:0] ST_BURNED   = 2'd2;

  // Fixed-point constants
  localparam logic [16:0] ONE_Q16          = 17'h10000;
  localparam logic [15:0] INV_SQRT2_Q16    = 16'd46341;
  localparam logic [15:0] EIGHT_TENTHS_Q16 = 16'd52429;
  localparam logic [12:0] TALLY_MAX        = 13'd8191;
  localparam logic [15:0] FUEL_CAP         = 16'd256;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_GRID_WIDTH    = 3'd0,
    REG_GRID_HEIGHT   = 3'd1,
    REG_BURN_RATE     = 3'd2,
    REG_BASE_SPREAD   = 3'd3,
    REG_WIND_STRENGTH = 3'd4,
    REG_WIND_COS      = 3'd5,
    REG_WIND_SIN      = 3'd6,
    REG_INV_SLOPE     = 3'd7
  } cfg_reg_t;

  // Operations of the shared multiplier
  typedef enum logic [3:0] {
    OP_NONE, OP_MF, OP_PV, OP_PM, OP_PB, OP_AD, OP_WF, OP_SE, OP_PW, OP_PS,
    OP_PD, OP_Q
  } mul_op_t;

  typedef struct packed {
    logic [6:0]         grid_width;
    logic [6:0]         grid_height;
    logic [15:0]        fuel_burn;
    logic [15:0]        spread_gain;
    logic [15:0]        wind_gain;
    logic signed [15:0] wind_cos;
    logic signed [15:0] wind_sin;
    logic [15:0]        inv_slope_scale;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [11:0]        cell_index;
    logic [1:0]         cell_state;
    logic [15:0]        cell_fuel;
    logic [15:0]        cell_moisture;
    logic [15:0]        cell_vegetation;
    logic signed [15:0] cell_elevation;
    logic [15:0]        random_draw;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  new_state;
    logic [15:0] new_fuel;
    logic        now_burning;
    logic [12:0] burning_total;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    accept;
    logic    wr_first;
    logic    wr_second;
    logic    div_start;
    logic    div_step;
    logic    rd_center;
    logic    latch_center;
    logic    q_init;
    mul_op_t mul_op;
    logic    nb_first;
    logic    nb_next;
    logic    rd_nb;
    logic    latch_nb;
    logic    finish;
    logic    res_null;
    logic    do_swap;
    logic    out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0] req;
    logic       in_range;
    logic       div_done;
    logic       center_unburned;
    logic       nb_valid;
    logic       nb_burning;
    logic       nb_last;
    logic       out_free;
  } dp_status_t;

  // Neighbor order: row offset -1..1, column offset -1..1, center skipped
  function automatic logic signed [1:0] nb_dr(input logic [2:0] k);
    logic signed [1:0] r;
    case (k)
      3'd0, 3'd1, 3'd2: r = -2'sd1;
      3'd3, 3'd4:       r = 2'sd0;
      default:          r = 2'sd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] nb_dc(input logic [2:0] k);
    logic signed [1:0] c;
    case (k)
      3'd0, 3'd3, 3'd5: c = -2'sd1;
      3'd1, 3'd6:       c = 2'sd0;
      default:          c = 2'sd1;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/wcas_ifs.sv =====
// Valid/ready channel interfaces: request, result and configuration write.
// No dependencies.
interface wcas_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [11:0] cell_index;
  logic [1:0]  cell_state;
  logic [15:0] cell_fuel;
  logic [15:0] cell_moisture;
  logic [15:0] cell_vegetation;
  logic signed [15:0] cell_elevation;
  logic [15:0] random_draw;
  modport source(output valid, req_type, cell_index, cell_state, cell_fuel,
                 cell_moisture, cell_vegetation, cell_elevation, random_draw,
                 input ready);
  modport sink(input valid, req_type, cell_index, cell_state, cell_fuel,
               cell_moisture, cell_vegetation, cell_elevation, random_draw,
               output ready);
endinterface

interface wcas_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  new_state;
  logic [15:0] new_fuel;
  logic        now_burning;
  logic [12:0] burning_total;
  modport source(output valid, new_state, new_fuel, now_burning, burning_total,
                 input ready);
  modport sink(input valid, new_state, new_fuel, now_burning, burning_total,
               output ready);
endinterface

interface wcas_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [15:0] wdata;
  modport source(output valid, reg_index, wdata, input ready);
  modport sink(input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/core/wcas_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module wcas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/core/wcas_ctrl.sv =====
// Controller state machine of the cell step block.
// Depends on wcas_pkg; drives the datapath through ctrl_cmd_t.
module wcas_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  wcas_pkg::dp_status_t status,
  output wcas_pkg::ctrl_cmd_t  cmd
);
  import wcas_pkg::*;

  typedef enum logic [19:0] {
    S_IDLE     = 20'h00001,
    S_DISPATCH = 20'h00002,
    S_WR_A     = 20'h00004,
    S_WR_B     = 20'h00008,
    S_DIV      = 20'h00010,
    S_CDATA    = 20'h00020,
    S_PV       = 20'h00040,
    S_PM       = 20'h00080,
    S_PB       = 20'h00100,
    S_NADDR    = 20'h00200,
    S_NDATA    = 20'h00400,
    S_WF       = 20'h00800,
    S_SE       = 20'h01000,
    S_PW       = 20'h02000,
    S_PS       = 20'h04000,
    S_PD       = 20'h08000,
    S_PQ       = 20'h10000,
    S_FIN      = 20'h20000,
    S_SWAP     = 20'h40000,
    S_DONE     = 20'h80000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_op = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status.req == REQ_SWAP) begin
          state_next = S_SWAP;
        end else if (status.in_range && status.req == REQ_WRITE) begin
          state_next = S_WR_A;
        end else if (status.in_range && status.req == REQ_UPDATE) begin
          cmd.div_start = 1'b1;
          cmd.rd_center = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.res_null = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_WR_A: begin
        cmd.wr_first = 1'b1;
        state_next   = S_WR_B;
      end
      S_WR_B: begin
        cmd.wr_second = 1'b1;
        state_next    = S_DONE;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_CDATA;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_CDATA: begin
        cmd.latch_center = 1'b1;
        cmd.q_init       = 1'b1;
        cmd.mul_op       = OP_MF;
        state_next       = status.center_unburned ? S_PV : S_FIN;
      end
      S_PV: begin
        cmd.mul_op = OP_PV;
        state_next = S_PM;
      end
      S_PM: begin
        cmd.mul_op = OP_PM;
        state_next = S_PB;
      end
      S_PB: begin
        cmd.mul_op   = OP_PB;
        cmd.nb_first = 1'b1;
        state_next   = S_NADDR;
      end
      S_NADDR: begin
        if (status.nb_valid) begin
          cmd.rd_nb  = 1'b1;
          state_next = S_NDATA;
        end else if (status.nb_last) begin
          state_next = S_FIN;
        end else begin
          cmd.nb_next = 1'b1;
        end
      end
      S_NDATA: begin
        cmd.latch_nb = 1'b1;
        cmd.mul_op   = OP_AD;
        if (status.nb_burning) begin
          state_next = S_WF;
        end else if (status.nb_last) begin
          state_next = S_FIN;
        end else begin
          cmd.nb_next = 1'b1;
          state_next  = S_NADDR;
        end
      end
      S_WF: begin
        cmd.mul_op = OP_WF;
        state_next = S_SE;
      end
      S_SE: begin
        cmd.mul_op = OP_SE;
        state_next = S_PW;
      end
      S_PW: begin
        cmd.mul_op = OP_PW;
        state_next = S_PS;
      end
      S_PS: begin
        cmd.mul_op = OP_PS;
        state_next = S_PD;
      end
      S_PD: begin
        cmd.mul_op = OP_PD;
        state_next = S_PQ;
      end
      S_PQ: begin
        cmd.mul_op = OP_Q;
        if (status.nb_last) begin
          state_next = S_FIN;
        end else begin
          cmd.nb_next = 1'b1;
          state_next  = S_NADDR;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_DONE;
      end
      S_SWAP: begin
        cmd.do_swap = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/wcas_dp.sv =====
// Datapath of the cell step block: grid memories, divider, multiplier
// chain, buffer and tally state, result register. Depends on wcas_pkg, wcas_ram.
module wcas_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  wcas_pkg::cfg_t       cfg,
  input  wcas_pkg::in_item_t   in_item,
  input  wcas_pkg::ctrl_cmd_t  cmd,
  output wcas_pkg::dp_status_t status,
  input  logic                 out_ready,
  output logic                 out_valid,
  output wcas_pkg::out_item_t  out_item
);
  import wcas_pkg::*;

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam logic [3:0] DIV_STEPS = 4'(IDX_W);

  // Effective grid size
  logic [6:0] weff, heff;
  always_comb begin
    if (cfg.grid_width == '0) begin
      weff = 7'd1;
    end else if (int'(cfg.grid_width) > MAX_WIDTH) begin
      weff = 7'(MAX_WIDTH);
    end else begin
      weff = cfg.grid_width;
    end
    if (cfg.grid_height == '0) begin
      heff = 7'd1;
    end else if (int'(cfg.grid_height) > MAX_HEIGHT) begin
      heff = 7'(MAX_HEIGHT);
    end else begin
      heff = cfg.grid_height;
    end
  end

  logic [13:0] area;
  assign area = {7'd0, weff} * {7'd0, heff};

  // Request and control registers
  in_item_t    rq;
  logic        in_range;
  logic        active;
  logic [12:0] tally;
  logic [AW-1:0] ca;
  assign ca = AW'(rq.cell_index);

  // Divider: row and column of the cell
  logic [11:0] div_q;
  logic [6:0]  div_r;
  logic [3:0]  div_cnt;
  logic [7:0]  trial;
  logic        trial_ge;
  assign trial    = {div_r, div_q[11]};
  assign trial_ge = (trial >= {1'b0, weff});

  // Center and neighbor values
  logic [1:0]  st_c;
  logic [15:0] fu_c;
  logic signed [15:0] te, ne;
  logic [2:0]  k;
  logic signed [1:0] dr, dc;
  logic        diag;

  // Chain registers
  logic [16:0] mf;
  logic [19:0] p0;
  logic [21:0] pn;
  logic signed [17:0] a_reg;
  logic [15:0] wf;
  logic [14:0] sf;
  logic [16:0] q;

  // Result registers
  out_item_t res;

  // Memory ports
  logic [1:0]  state_rd;
  logic [15:0] fuel_rd, moist_rd, veg_rd, elev_rd;
  logic        sp_we, sp_re, cp_we, cp_re, ep_re;
  logic [AW:0] sp_addr;
  logic [AW-1:0] cp_addr, ep_addr;
  logic [1:0]  sp_wstate;
  logic [15:0] sp_wfuel;

  // Neighbor geometry
  logic signed [13:0] r_s;
  logic signed [8:0]  c_s;
  logic [13:0] row_off, nb_lin;
  logic [AW-1:0] nb_addr;
  logic        nb_valid;

  assign dr   = nb_dr(k);
  assign dc   = nb_dc(k);
  assign diag = (dr != 2'sd0) && (dc != 2'sd0);
  assign r_s  = $signed({2'b00, div_q}) + $signed({{12{dr[1]}}, dr});
  assign c_s  = $signed({2'b00, div_r}) + $signed({{7{dc[1]}}, dc});
  assign nb_valid = !r_s[13] && (r_s < $signed({7'd0, heff}))
                 && !c_s[8] && (c_s < $signed({2'b00, weff}));

  always_comb begin
    case (dr)
      2'sd1:   row_off = {7'd0, weff};
      -2'sd1:  row_off = 14'd0 - {7'd0, weff};
      default: row_off = 14'd0;
    endcase
  end
  assign nb_lin  = {2'b00, rq.cell_index} + row_off + {{12{dc[1]}}, dc};
  assign nb_addr = AW'(nb_lin);

  // Wind alignment of the current neighbor
  logic signed [17:0] s_val, s_c, s_r;
  always_comb begin
    case (dc)
      2'sd1:   s_c = -{{2{cfg.wind_cos[15]}}, cfg.wind_cos};
      -2'sd1:  s_c = {{2{cfg.wind_cos[15]}}, cfg.wind_cos};
      default: s_c = 18'sd0;
    endcase
    case (dr)
      2'sd1:   s_r = {{2{cfg.wind_sin[15]}}, cfg.wind_sin};
      -2'sd1:  s_r = -{{2{cfg.wind_sin[15]}}, cfg.wind_sin};
      default: s_r = 18'sd0;
    endcase
  end
  assign s_val = s_c + s_r;

  // Shared multiplier operand selection
  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [42:0] prod;
  logic [8:0]  fuel_cap;
  logic [16:0] qm;
  logic signed [16:0] dz;
  assign fuel_cap = (fu_c > FUEL_CAP) ? 9'd256 : fu_c[8:0];
  assign qm       = ONE_Q16 - pn[16:0];
  assign dz       = {te[15], te} - {ne[15], ne};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      OP_MF: begin
        mul_a = {9'd0, moist_rd};
        mul_b = {2'd0, EIGHT_TENTHS_Q16};
      end
      OP_PV: begin
        mul_a = {8'd0, fuel_cap, 8'd0};
        mul_b = {2'd0, veg_rd};
      end
      OP_PM: begin
        mul_a = {5'd0, p0};
        mul_b = {1'b0, mf};
      end
      OP_PB: begin
        mul_a = {5'd0, p0};
        mul_b = {2'd0, cfg.spread_gain};
      end
      OP_AD: begin
        mul_a = {{7{s_val[17]}}, s_val};
        mul_b = {2'd0, INV_SQRT2_Q16};
      end
      OP_WF: begin
        mul_a = {{7{a_reg[17]}}, a_reg};
        mul_b = {2'd0, cfg.wind_gain};
      end
      OP_SE: begin
        mul_a = {{8{dz[16]}}, dz};
        mul_b = {2'd0, cfg.inv_slope_scale};
      end
      OP_PW: begin
        mul_a = {5'd0, p0};
        mul_b = {2'd0, wf};
      end
      OP_PS: begin
        mul_a = {3'd0, pn};
        mul_b = {3'd0, sf};
      end
      OP_PD: begin
        mul_a = {3'd0, pn};
        mul_b = {2'd0, INV_SQRT2_Q16};
      end
      OP_Q: begin
        mul_a = {8'd0, q};
        mul_b = {1'b0, qm};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Post-processing of the product
  logic signed [42:0] ad_t, wf_sum;
  logic signed [17:0] a_next;
  logic [15:0] wf_next;
  logic signed [9:0]  e_cl;
  logic signed [16:0] sf_s;
  logic [21:0] pd_v, pn_pd;
  always_comb begin
    ad_t   = prod + 43'sd32768;
    a_next = diag ? 18'(ad_t >>> 16) : s_val;
    wf_sum = 43'sd16384 + (prod >>> 12);
    if (wf_sum < 43'sd4096) begin
      wf_next = 16'd4096;
    end else if (wf_sum > 43'sd32768) begin
      wf_next = 16'd32768;
    end else begin
      wf_next = 16'(wf_sum);
    end
    if (prod < -43'sd256) begin
      e_cl = -10'sd256;
    end else if (prod > 43'sd256) begin
      e_cl = 10'sd256;
    end else begin
      e_cl = 10'(prod);
    end
    sf_s  = 17'sd16384 + {{2{e_cl[9]}}, e_cl, 5'b0};
    pd_v  = diag ? prod[37:16] : pn;
    pn_pd = (pd_v > {5'd0, ONE_Q16}) ? {5'd0, ONE_Q16} : pd_v;
  end

  // Decide the next state of the cell
  logic [1:0]  ns;
  logic [15:0] nf, fu_less;
  logic        ignite;
  assign ignite  = (q < ONE_Q16) && ({1'b0, rq.random_draw} < (ONE_Q16 - q));
  assign fu_less = (fu_c > cfg.fuel_burn) ? (fu_c - cfg.fuel_burn) : 16'd0;
  always_comb begin
    ns = st_c;
    nf = fu_c;
    case (st_c)
      ST_BURNING: begin
        nf = fu_less;
        ns = (fu_less == 16'd0) ? ST_BURNED : ST_BURNING;
      end
      ST_UNBURNED: begin
        ns = ignite ? ST_BURNING : ST_UNBURNED;
      end
      default: begin
        ns = st_c;
        nf = fu_c;
      end
    endcase
  end

  // Memory port steering
  always_comb begin
    sp_we     = 1'b0;
    sp_re     = 1'b0;
    cp_we     = 1'b0;
    cp_re     = 1'b0;
    ep_re     = 1'b0;
    sp_addr   = {active, ca};
    cp_addr   = ca;
    ep_addr   = ca;
    sp_wstate = rq.cell_state;
    sp_wfuel  = rq.cell_fuel;
    if (cmd.wr_first) begin
      sp_we   = 1'b1;
      cp_we   = 1'b1;
      sp_addr = {1'b0, ca};
    end else if (cmd.wr_second) begin
      sp_we   = 1'b1;
      sp_addr = {1'b1, ca};
    end else if (cmd.rd_center) begin
      sp_re = 1'b1;
      cp_re = 1'b1;
      ep_re = 1'b1;
    end else if (cmd.rd_nb) begin
      sp_re   = 1'b1;
      ep_re   = 1'b1;
      sp_addr = {active, nb_addr};
      ep_addr = nb_addr;
    end else if (cmd.finish) begin
      sp_we     = 1'b1;
      sp_addr   = {~active, ca};
      sp_wstate = ns;
      sp_wfuel  = nf;
    end
  end

  wcas_ram #(.WIDTH(2), .DEPTH(2 * CELLS)) u_state_ram (
    .clk(clk), .we(sp_we), .re(sp_re), .addr(sp_addr),
    .wdata(sp_wstate), .rdata(state_rd)
  );
  wcas_ram #(.WIDTH(16), .DEPTH(2 * CELLS)) u_fuel_ram (
    .clk(clk), .we(sp_we), .re(sp_re), .addr(sp_addr),
    .wdata(sp_wfuel), .rdata(fuel_rd)
  );
  wcas_ram #(.WIDTH(16), .DEPTH(CELLS)) u_moist_ram (
    .clk(clk), .we(cp_we), .re(cp_re), .addr(cp_addr),
    .wdata(rq.cell_moisture), .rdata(moist_rd)
  );
  wcas_ram #(.WIDTH(16), .DEPTH(CELLS)) u_veg_ram (
    .clk(clk), .we(cp_we), .re(cp_re), .addr(cp_addr),
    .wdata(rq.cell_vegetation), .rdata(veg_rd)
  );
  wcas_ram #(.WIDTH(16), .DEPTH(CELLS)) u_elev_ram (
    .clk(clk), .we(cp_we), .re(ep_re), .addr(ep_addr),
    .wdata(rq.cell_elevation), .rdata(elev_rd)
  );

  // Control state: buffer select, tally, divider count, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      tally     <= '0;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.div_start) begin
        div_cnt <= DIV_STEPS;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt - 4'd1;
      end
      if (cmd.do_swap) begin
        active <= ~active;
        tally  <= '0;
      end else if (cmd.finish && ns == ST_BURNING && tally != TALLY_MAX) begin
        tally <= tally + 13'd1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rq       <= in_item;
      in_range <= ({2'b00, in_item.cell_index} < area);
    end
    // Step the restoring divider
    if (cmd.div_start) begin
      div_q <= rq.cell_index;
      div_r <= '0;
    end else if (cmd.div_step) begin
      div_r <= trial_ge ? 7'(trial - {1'b0, weff}) : trial[6:0];
      div_q <= {div_q[10:0], trial_ge};
    end
    if (cmd.latch_center) begin
      st_c <= state_rd;
      fu_c <= fuel_rd;
      te   <= elev_rd;
    end
    if (cmd.q_init) begin
      q <= ONE_Q16;
    end
    if (cmd.nb_first) begin
      k <= 3'd0;
    end else if (cmd.nb_next) begin
      k <= k + 3'd1;
    end
    if (cmd.latch_nb) begin
      ne <= elev_rd;
    end
    // Write back the multiplier result
    case (cmd.mul_op)
      OP_MF: mf    <= ONE_Q16 - {1'b0, prod[31:16]};
      OP_PV: p0    <= prod[35:16];
      OP_PM: p0    <= prod[35:16];
      OP_PB: p0    <= prod[31:12];
      OP_AD: a_reg <= a_next;
      OP_WF: wf    <= wf_next;
      OP_SE: sf    <= 15'(sf_s);
      OP_PW: pn    <= prod[35:14];
      OP_PS: pn    <= prod[35:14];
      OP_PD: pn    <= pn_pd;
      OP_Q:  q     <= prod[32:16];
      default: ;
    endcase
    // Hold the result of the item
    if (cmd.wr_second) begin
      res <= '{new_state: rq.cell_state, new_fuel: rq.cell_fuel,
               now_burning: (rq.cell_state == ST_BURNING), burning_total: 13'd0};
    end else if (cmd.res_null) begin
      res <= '0;
    end else if (cmd.do_swap) begin
      res <= '{new_state: 2'd0, new_fuel: 16'd0, now_burning: 1'b0,
               burning_total: tally};
    end else if (cmd.finish) begin
      res <= '{new_state: ns, new_fuel: nf, now_burning: (ns == ST_BURNING),
               burning_total: 13'd0};
    end
    if (cmd.out_load) begin
      out_item <= res;
    end
  end

  // Status to the controller
  assign status.req             = rq.req_type;
  assign status.in_range        = in_range;
  assign status.div_done        = (div_cnt == 4'd0);
  assign status.center_unburned = (state_rd == ST_UNBURNED);
  assign status.nb_valid        = nb_valid;
  assign status.nb_burning      = (state_rd == ST_BURNING);
  assign status.nb_last         = (k == 3'd7);
  assign status.out_free        = !out_valid || out_ready;

endmodule

// ===== rtl/core/wildfire_cell_automaton_step_top.sv =====
// Wildfire cell step block. One request at a time. An update splits the cell
// index into row and column with a 12-step restoring divider while it reads
// the center cell; a burning or inert cell then finishes. An unburned cell
// adds fuel terms on the shared multiplier, then visits its 8 neighbors in
// turn through the single-port grid memories: a neighbor outside the grid is
// skipped, one that is not burning is read, and a burning one also runs the
// wind, slope and spread terms on the multiplier. The next request is taken
// while a result waits at the output. Grid memories hold no reset value; the
// block does not clear them after reset.
// Depends on wcas_pkg, wcas_ifs, wcas_ctrl, wcas_dp.
module wildfire_cell_automaton_step_top (
  input  logic       clk,
  input  logic       rst,
  wcas_in_if.sink    in_ch,
  wcas_out_if.source out_ch,
  wcas_cfg_if.sink   cfg_ch
);
  import wcas_pkg::*;

  cfg_t       cfg;
  in_item_t   in_item;
  out_item_t  out_item;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width      <= 7'd64;
      cfg.grid_height     <= 7'd64;
      cfg.fuel_burn       <= 16'd256;
      cfg.spread_gain     <= 16'd4096;
      cfg.wind_gain       <= 16'd0;
      cfg.wind_cos        <= 16'sd16384;
      cfg.wind_sin        <= 16'sd0;
      cfg.inv_slope_scale <= 16'd256;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.reg_index))
        REG_GRID_WIDTH:    cfg.grid_width      <= cfg_ch.wdata[6:0];
        REG_GRID_HEIGHT:   cfg.grid_height     <= cfg_ch.wdata[6:0];
        REG_BURN_RATE:     cfg.fuel_burn       <= cfg_ch.wdata;
        REG_BASE_SPREAD:   cfg.spread_gain     <= cfg_ch.wdata;
        REG_WIND_STRENGTH: cfg.wind_gain       <= cfg_ch.wdata;
        REG_WIND_COS:      cfg.wind_cos        <= cfg_ch.wdata;
        REG_WIND_SIN:      cfg.wind_sin        <= cfg_ch.wdata;
        REG_INV_SLOPE:     cfg.inv_slope_scale <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // Gather the request beat
  assign in_item = '{req_type: in_ch.req_type, cell_index: in_ch.cell_index,
                     cell_state: in_ch.cell_state, cell_fuel: in_ch.cell_fuel,
                     cell_moisture: in_ch.cell_moisture,
                     cell_vegetation: in_ch.cell_vegetation,
                     cell_elevation: in_ch.cell_elevation,
                     random_draw: in_ch.random_draw};
  assign in_ch.ready = in_ready;

  wcas_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ready),
    .status(status), .cmd(cmd)
  );

  wcas_dp u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .in_item(in_item), .cmd(cmd),
    .status(status), .out_ready(out_ch.ready), .out_valid(out_valid),
    .out_item(out_item)
  );

  // Drive the result beat
  assign out_ch.valid         = out_valid;
  assign out_ch.new_state     = out_item.new_state;
  assign out_ch.new_fuel      = out_item.new_fuel;
  assign out_ch.now_burning   = out_item.now_burning;
  assign out_ch.burning_total = out_item.burning_total;

endmodule

// ===== rtl/core/wcas_checker.sv =====
// Port-level checks of the cell step block, bound to its top level.
// Depends on wcas_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wcas_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  new_state,
  input logic [15:0] new_fuel,
  input logic        now_burning,
  input logic [12:0] burning_total
);
  import wcas_pkg::*;

  // A stalled result beat stays put
  `WCAS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(new_state) && $stable(new_fuel) && $stable(now_burning) && $stable(burning_total))
  // The burning flag follows the reported state
  `WCAS_ASSERT_NOW(a_burn_flag, clk, rst, out_valid, now_burning == (new_state == ST_BURNING))
  // A tally comes only with an otherwise empty result
  `WCAS_ASSERT_NOW(a_total_alone, clk, rst, out_valid && burning_total != 13'd0, new_state == ST_UNBURNED && new_fuel == 16'd0 && !now_burning)
  // One request in work at a time
  `WCAS_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready)

endmodule

bind wildfire_cell_automaton_step_top wcas_checker u_wcas_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .new_state(out_ch.new_state), .new_fuel(out_ch.new_fuel),
  .now_burning(out_ch.now_burning), .burning_total(out_ch.burning_total)
);
